// ===== hw/rtl/ptds_pkg.sv =====
package ptds_pkg;

   localparam int DEFAULT_MAX_TASKS = 16;
   localparam int MAX_IDX_W = 8;
   localparam int TIME_W = 63;
   localparam int PERIOD_W = 48;

   localparam logic [1:0] KIND_REGISTER = 2'd0;
   localparam logic [1:0] KIND_DISPATCH = 2'd1;
   localparam logic [1:0] KIND_SET_ACTIVE = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO_PERIOD = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [TIME_W-1:0] current_time;
      logic [PERIOD_W-1:0] period;
      logic [3:0] task_index;
      logic enable;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic fired;
      logic [3:0] fired_task;
      logic [4:0] tasks_in_use;
   } rsp_type;

   typedef struct packed {
      logic [MAX_IDX_W-1:0] sel_idx;
      logic period_we;
      logic [PERIOD_W-1:0] period;
      logic due_we;
      logic [TIME_W-1:0] due;
      logic active_we;
      logic active;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic found;
      logic [MAX_IDX_W-1:0] best_idx;
      logic [TIME_W-1:0] best_due;
      logic [PERIOD_W-1:0] best_period;
   } token_type;

   function automatic logic [TIME_W-1:0] due_after(input logic [TIME_W-1:0] now,
                                                   input logic [PERIOD_W-1:0] per);
      logic [TIME_W:0] sum;
      sum = {1'b0, now} + {{(TIME_W+1-PERIOD_W){1'b0}}, per};
      due_after = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/ptds_cell.sv =====
module ptds_cell #(
   parameter int INDEX = 0
) (
   input  logic clock,
   input  logic reset,
   input  ptds_pkg::cmd_type cmd,
   input  logic [ptds_pkg::TIME_W-1:0] now,
   input  ptds_pkg::token_type token_in,
   output ptds_pkg::token_type token_out
);
   import ptds_pkg::*;

   logic [PERIOD_W-1:0] period_ff;
   logic [TIME_W-1:0] due_ff;
   logic active_ff;
   token_type token_ff;
   token_type token_in_sel;
   logic hit;
   logic eligible;
   logic take;

   assign hit = (cmd.sel_idx == MAX_IDX_W'(INDEX));
   assign eligible = active_ff && (due_ff <= now);
   assign take = eligible && (!token_in.found || (due_ff < token_in.best_due));

   always_comb begin
      token_in_sel = token_in;
      if (take) begin
         token_in_sel.found = 1'b1;
         token_in_sel.best_idx = MAX_IDX_W'(INDEX);
         token_in_sel.best_due = due_ff;
         token_in_sel.best_period = period_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (hit && cmd.period_we) begin
         period_ff <= cmd.period;
      end
      if (hit && cmd.due_we) begin
         due_ff <= cmd.due;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (hit && cmd.active_we) begin
         active_ff <= cmd.active;
      end
   end

   // token moves one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff <= token_in_sel;
      end
   end

   assign token_out = token_ff;

endmodule

// ===== hw/rtl/periodic_task_earliest_due_scheduler_unit.sv =====
// channel   ports                        direction  accepted when
// request   start, busy, req_item        in         start high and busy low
// result    rsp_valid, rsp_item          out        rsp_valid high (one cycle)
//
// register, set-active and unused kinds: result on the next cycle.
// dispatch: a search token walks the row of task cells, one cell per cycle, then the
// winner is rescheduled; busy stays high until the token leaves the last cell.
// reset (synchronous, active high) clears the task count and all active flags.
// the receiver cannot stall; each result is shown for exactly one cycle.
module periodic_task_earliest_due_scheduler_unit #(
   parameter int MAX_TASKS = ptds_pkg::DEFAULT_MAX_TASKS
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  ptds_pkg::req_type req_item,
   output logic rsp_valid,
   output ptds_pkg::rsp_type rsp_item
);
   import ptds_pkg::*;

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   req_type req_ff;
   logic launch_ff, launch_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   cmd_type cmd;
   token_type tok [MAX_TASKS+1];
   logic accept;
   token_type last;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign last = tok[MAX_TASKS];

   always_comb begin
      tok[0] = '0;
      tok[0].valid = launch_ff;
   end

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      ptds_cell #(
         .INDEX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .cmd(cmd),
         .now(req_ff.current_time),
         .token_in(tok[i]),
         .token_out(tok[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      launch_in = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_in = '0;
               rsp_in.tasks_in_use = 5'(total_ff);
               rsp_valid_in = 1'b1;
               unique case (req_item.kind)
                  KIND_REGISTER: begin
                     if (total_ff >= CNT_W'(MAX_TASKS)) begin
                        rsp_in.status = STATUS_FULL;
                     end else if (req_item.period == '0) begin
                        rsp_in.status = STATUS_ZERO_PERIOD;
                     end else begin
                        cmd.sel_idx = MAX_IDX_W'(total_ff);
                        cmd.period_we = 1'b1;
                        cmd.period = req_item.period;
                        cmd.due_we = 1'b1;
                        cmd.due = due_after(req_item.current_time, req_item.period);
                        cmd.active_we = 1'b1;
                        cmd.active = 1'b1;
                        total_in = total_ff + 1'b1;
                        rsp_in.fired_task = 4'(total_ff);
                        rsp_in.tasks_in_use = 5'(total_ff + 1'b1);
                     end
                  end
                  KIND_DISPATCH: begin
                     rsp_valid_in = 1'b0;
                     launch_in = 1'b1;
                     state_in = ST_SCAN;
                  end
                  KIND_SET_ACTIVE: begin
                     if ((CNT_W+4)'(req_item.task_index) < (CNT_W+4)'(total_ff)) begin
                        cmd.sel_idx = MAX_IDX_W'(req_item.task_index);
                        cmd.active_we = 1'b1;
                        cmd.active = req_item.enable;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (last.valid) begin
               rsp_in = '0;
               rsp_in.tasks_in_use = 5'(total_ff);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
               if (last.found) begin
                  rsp_in.fired = 1'b1;
                  rsp_in.fired_task = last.best_idx[3:0];
                  cmd.sel_idx = last.best_idx;
                  cmd.due_we = 1'b1;
                  cmd.due = due_after(req_ff.current_time, last.best_period);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         launch_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         launch_ff <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule
